### hw/rtl/fcpd_pkg.sv
// ----------------------------------------------------------------------------
// fcpd_pkg
// shared types and constants of the frame and command packet deframer
// ----------------------------------------------------------------------------
package fcpd_pkg;

    localparam int DIM_W   = 13;
    localparam int LIMIT_W = 25;
    localparam int CNT_W   = 2;

    localparam logic [7:0] SYNC_BYTE       = 8'hDA;
    localparam logic [7:0] TYPE_CMD        = 8'h7F;
    localparam logic [7:0] TYPE_FRAME      = 8'h7E;
    localparam logic [7:0] CMD_BRIGHT      = 8'h01;
    localparam logic [7:0] CMD_COLOUR_TEMP = 8'h02;
    localparam logic [7:0] CMD_RES         = 8'h04;

    localparam logic [CNT_W-1:0]   LAST_FIELD_BYTE = 2'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_PAD       = 25'd256;
    localparam logic [DIM_W-1:0]   RESET_WIDTH     = 13'd1024;
    localparam logic [DIM_W-1:0]   RESET_HEIGHT    = 13'd768;
    localparam logic [LIMIT_W-1:0] RESET_LIMIT     = 25'd786688;

    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_TYPE    = 8'b0000_0010,
        PH_CMD     = 8'b0000_0100,
        PH_RES     = 8'b0000_1000,
        PH_VALUE   = 8'b0001_0000,
        PH_FLAGS   = 8'b0010_0000,
        PH_LEN     = 8'b0100_0000,
        PH_PAYLOAD = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD    = 3'd0,
        KIND_RESOLUTION = 3'd1,
        KIND_BRIGHTNESS = 3'd2,
        KIND_WARMTH     = 3'd3,
        KIND_ERROR      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_SYNC     = 2'd0,
        ERR_TYPE     = 2'd1,
        ERR_TOO_LONG = 2'd2
    } err_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } dims_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data_byte;
        logic             keyframe;
        logic             is_first;
        logic             is_last;
        logic [DIM_W-1:0] new_width;
        logic [DIM_W-1:0] new_height;
        err_t             error_code;
    } result_t;

endpackage

### hw/rtl/fcpd_limit.sv
// ----------------------------------------------------------------------------
// fcpd_limit
// registered payload length limit, width times height plus header margin
// ----------------------------------------------------------------------------
module fcpd_limit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcpd_pkg::dims_t               dims,
    output logic [fcpd_pkg::LIMIT_W-1:0]  limit
);

    logic [2*fcpd_pkg::DIM_W-1:0] product;
    logic [fcpd_pkg::LIMIT_W-1:0] limit_reg;
    logic [fcpd_pkg::LIMIT_W-1:0] limit_next;

    assign product    = dims.width * dims.height;
    assign limit_next = product[fcpd_pkg::LIMIT_W-1:0] + fcpd_pkg::LIMIT_PAD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= fcpd_pkg::RESET_LIMIT;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign limit = limit_reg;

endmodule

### hw/rtl/fcpd_parser.sv
// ----------------------------------------------------------------------------
// fcpd_parser
// packet state machine, header field assembly and result forming
// ----------------------------------------------------------------------------
module fcpd_parser
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [7:0]                    rx_byte,
    input  logic [fcpd_pkg::LIMIT_W-1:0]  limit,
    output fcpd_pkg::dims_t               dims,
    output logic                          res_valid,
    output fcpd_pkg::result_t             res
);

    fcpd_pkg::phase_t             phase_reg, phase_next;
    logic [fcpd_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [23:0]                  asm_reg, asm_next;
    logic [7:0]                   code_reg, code_next;
    logic                         key_reg, key_next;
    logic                         first_reg, first_next;
    logic [fcpd_pkg::LIMIT_W-1:0] remain_reg, remain_next;
    fcpd_pkg::dims_t              dims_reg, dims_next;

    logic [31:0]                  field;
    logic [15:0]                  w16;
    logic [15:0]                  h16;
    logic                         dims_ok;
    logic [fcpd_pkg::LIMIT_W-1:0] remain_dec;

    assign field      = {rx_byte, asm_reg};
    assign w16        = field[15:0];
    assign h16        = field[31:16];
    assign dims_ok    = (w16 != 16'd0) && (h16 != 16'd0)
                        && (w16 <= 16'(MAX_DIM)) && (h16 <= 16'(MAX_DIM));
    assign remain_dec = (remain_reg == '0) ? '0 : remain_reg - 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        asm_next    = asm_reg;
        code_next   = code_reg;
        key_next    = key_reg;
        first_next  = first_reg;
        remain_next = remain_reg;
        dims_next   = dims_reg;
        res_valid   = 1'b0;
        res         = '0;
        unique case (phase_reg)
            fcpd_pkg::PH_HUNT:
            begin
                if (rx_byte == fcpd_pkg::SYNC_BYTE)
                begin
                    phase_next = fcpd_pkg::PH_TYPE;
                end
                else
                begin
                    res_valid      = 1'b1;
                    res.kind       = fcpd_pkg::KIND_ERROR;
                    res.error_code = fcpd_pkg::ERR_SYNC;
                end
            end
            fcpd_pkg::PH_TYPE:
            begin
                if (rx_byte == fcpd_pkg::TYPE_CMD)
                begin
                    phase_next = fcpd_pkg::PH_CMD;
                end
                else if (rx_byte == fcpd_pkg::TYPE_FRAME)
                begin
                    phase_next = fcpd_pkg::PH_FLAGS;
                end
                else
                begin
                    phase_next     = fcpd_pkg::PH_HUNT;
                    res_valid      = 1'b1;
                    res.kind       = fcpd_pkg::KIND_ERROR;
                    res.error_code = fcpd_pkg::ERR_TYPE;
                end
            end
            fcpd_pkg::PH_CMD:
            begin
                code_next  = rx_byte;
                count_next = '0;
                phase_next = (rx_byte == fcpd_pkg::CMD_RES) ? fcpd_pkg::PH_RES
                                                            : fcpd_pkg::PH_VALUE;
            end
            fcpd_pkg::PH_RES:
            begin
                asm_next   = field[31:8];
                count_next = count_reg + 1'b1;
                if (count_reg == fcpd_pkg::LAST_FIELD_BYTE)
                begin
                    phase_next = fcpd_pkg::PH_HUNT;
                    if (dims_ok)
                    begin
                        dims_next.width  = w16[fcpd_pkg::DIM_W-1:0];
                        dims_next.height = h16[fcpd_pkg::DIM_W-1:0];
                        res_valid        = 1'b1;
                        res.kind         = fcpd_pkg::KIND_RESOLUTION;
                        res.new_width    = w16[fcpd_pkg::DIM_W-1:0];
                        res.new_height   = h16[fcpd_pkg::DIM_W-1:0];
                    end
                end
            end
            fcpd_pkg::PH_VALUE:
            begin
                phase_next    = fcpd_pkg::PH_HUNT;
                res.data_byte = rx_byte;
                if (code_reg == fcpd_pkg::CMD_BRIGHT)
                begin
                    res_valid = 1'b1;
                    res.kind  = fcpd_pkg::KIND_BRIGHTNESS;
                end
                else if (code_reg == fcpd_pkg::CMD_COLOUR_TEMP)
                begin
                    res_valid = 1'b1;
                    res.kind  = fcpd_pkg::KIND_WARMTH;
                end
            end
            fcpd_pkg::PH_FLAGS:
            begin
                key_next   = rx_byte[0];
                count_next = '0;
                phase_next = fcpd_pkg::PH_LEN;
            end
            fcpd_pkg::PH_LEN:
            begin
                asm_next   = field[31:8];
                count_next = count_reg + 1'b1;
                if (count_reg == fcpd_pkg::LAST_FIELD_BYTE)
                begin
                    if (field > {{(32 - fcpd_pkg::LIMIT_W){1'b0}}, limit})
                    begin
                        phase_next     = fcpd_pkg::PH_HUNT;
                        res_valid      = 1'b1;
                        res.kind       = fcpd_pkg::KIND_ERROR;
                        res.error_code = fcpd_pkg::ERR_TOO_LONG;
                    end
                    else if (field == 32'd0)
                    begin
                        phase_next = fcpd_pkg::PH_HUNT;
                    end
                    else
                    begin
                        remain_next = field[fcpd_pkg::LIMIT_W-1:0];
                        first_next  = 1'b1;
                        phase_next  = fcpd_pkg::PH_PAYLOAD;
                    end
                end
            end
            fcpd_pkg::PH_PAYLOAD:
            begin
                res_valid     = 1'b1;
                res.kind      = fcpd_pkg::KIND_PAYLOAD;
                res.data_byte = rx_byte;
                res.keyframe  = key_reg;
                res.is_first  = first_reg;
                res.is_last   = (remain_reg <= 1);
                first_next    = 1'b0;
                remain_next   = remain_dec;
                if (remain_dec == '0)
                begin
                    phase_next = fcpd_pkg::PH_HUNT;
                end
            end
            default:
            begin
                phase_next = fcpd_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= fcpd_pkg::PH_HUNT;
            count_reg  <= '0;
            asm_reg    <= '0;
            code_reg   <= '0;
            key_reg    <= 1'b0;
            first_reg  <= 1'b0;
            remain_reg <= '0;
            dims_reg   <= '{width: fcpd_pkg::RESET_WIDTH, height: fcpd_pkg::RESET_HEIGHT};
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            asm_reg    <= asm_next;
            code_reg   <= code_next;
            key_reg    <= key_next;
            first_reg  <= first_next;
            remain_reg <= remain_next;
            dims_reg   <= dims_next;
        end
    end

    assign dims = dims_reg;

endmodule

### hw/rtl/fcpd_out_reg.sv
// ----------------------------------------------------------------------------
// fcpd_out_reg
// result register towards the master-side stream
// ----------------------------------------------------------------------------
module fcpd_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  fcpd_pkg::result_t res,
    input  logic              out_ready,
    output logic              in_ready,
    output logic              out_valid,
    output fcpd_pkg::result_t out_res
);

    logic              valid_reg;
    fcpd_pkg::result_t res_reg;

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### hw/rtl/frame_command_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// frame_command_packet_deframer_top
// link byte deframer for command and frame packets
// ----------------------------------------------------------------------------
// result: the beat for an accepted byte is registered in the output register and is valid in the next cycle
// throughput: one byte per cycle, limited by the single parser state update, while the output register can take a beat
// reset: asynchronous, hunting for sync, 1024 x 768 frame size, output empty
// ----------------------------------------------------------------------------
module frame_command_packet_deframer_top
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // data_byte, new_width, new_height, error_code
    output logic [4:0]  m_axis_tuser,   // kind, keyframe, is_first
    output logic        m_axis_tlast    // is_last
);

    logic                         accept;
    logic                         res_valid;
    fcpd_pkg::result_t            res;
    fcpd_pkg::result_t            out_res;
    fcpd_pkg::dims_t              dims;
    logic [fcpd_pkg::LIMIT_W-1:0] limit;

    assign accept = s_axis_tvalid && s_axis_tready;

    fcpd_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .rx_byte   (s_axis_tdata),
        .limit     (limit),
        .dims      (dims),
        .res_valid (res_valid),
        .res       (res)
    );

    fcpd_limit u_limit (
        .clk   (clk),
        .rst_n (rst_n),
        .dims  (dims),
        .limit (limit)
    );

    fcpd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && res_valid),
        .res       (res),
        .out_ready (m_axis_tready),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {4'd0, out_res.error_code, out_res.new_height,
                           out_res.new_width, out_res.data_byte};
    assign m_axis_tuser = {out_res.is_first, out_res.keyframe, out_res.kind};
    assign m_axis_tlast = out_res.is_last;

endmodule
